### hdl/cpms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpms_pkg: shared types and constants for collatz_path_max_search
// Value width, alpha limit, sequencer states, shared adder operations and
// the adder result record.
// ----------------------------------------------------------------------------
package cpms_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int PORT_WIDTH  = 64;
   localparam int ALPHA_LIMIT = 40;
   localparam int ALPHA_WIDTH = $clog2(ALPHA_LIMIT + 2);
   localparam int SUM_WIDTH   = VALUE_WIDTH + 2;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [ALPHA_WIDTH-1:0] alpha_type;
   typedef logic [SUM_WIDTH-1:0]   sum_type;

   typedef enum logic [1:0] {
      ALU_INC,
      ALU_TRIPLE,
      ALU_DEC
   } alu_op_type;

   typedef struct packed {
      value_type sum;
      logic      over;
   } alu_res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_STRIP_V,
      ST_INC,
      ST_STRIP_I,
      ST_TRIPLE,
      ST_DEC,
      ST_UPDATE,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

### hdl/cpms_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpms_alu: shared adder of the trajectory walk
// Increment, multiply by three (a + 2a) and decrement on one adder, with a
// flag raised when an increment or a triple leaves the value width.
// ----------------------------------------------------------------------------
module cpms_alu (
   input  wire cpms_pkg::alu_op_type  op,
   input  wire cpms_pkg::value_type   a,
   output cpms_pkg::alu_res_type      res
);

   cpms_pkg::sum_type wide_a;
   cpms_pkg::sum_type wide_b;
   cpms_pkg::sum_type wide_sum;

   always_comb begin
      wide_a = {2'b00, a};
      unique case (op)
         cpms_pkg::ALU_INC:    wide_b = cpms_pkg::SUM_WIDTH'(1);
         cpms_pkg::ALU_TRIPLE: wide_b = {1'b0, a, 1'b0};
         cpms_pkg::ALU_DEC:    wide_b = '1;
         default:              wide_b = '0;
      endcase
      wide_sum = wide_a + wide_b;
   end

   always_comb begin
      res.sum  = wide_sum[cpms_pkg::VALUE_WIDTH-1:0];
      res.over = (op != cpms_pkg::ALU_DEC) &&
                 (|wide_sum[cpms_pkg::SUM_WIDTH-1:cpms_pkg::VALUE_WIDTH]);
   end

endmodule
`default_nettype wire

### hdl/collatz_path_max_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// collatz_path_max_search: running maximum over accelerated Collatz paths
// One start value enters on the req_ channel when req_valid is high and
// req_stall is low; req_stall is high while a path is being walked. One
// result per start leaves on the rsp_ channel: the running maximum after
// the path, whether the path raised it, and whether a step overflowed.
// Each step runs on one shared adder: strip the trailing zeros a bit a
// cycle, increment, strip alpha zeros, multiply by three alpha times,
// decrement, update the maximum, test the loop. A start of zero, one or
// two goes from its first loop test straight to delivery.
// The result waits in an output register: a new start is taken while the
// receiver stalls, and the walk holds before delivery until the register
// is free. Reset clears the maximum to zero and drops any pending result.
// ----------------------------------------------------------------------------
module collatz_path_max_search (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [cpms_pkg::PORT_WIDTH-1:0]      req_start_value,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [cpms_pkg::PORT_WIDTH-1:0]      rsp_running_maximum,
   output logic                                 rsp_record_raised,
   output logic                                 rsp_overflow_seen
);

   cpms_pkg::state_type   state_ff, state_in;
   cpms_pkg::value_type   start_ff, start_in;
   cpms_pkg::value_type   v_ff, v_in;
   cpms_pkg::value_type   best_ff, best_in;
   cpms_pkg::alpha_type   alpha_ff, alpha_in;
   logic                  raised_ff, raised_in;
   logic                  ovf_ff, ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cpms_pkg::value_type   rsp_max_ff, rsp_max_in;
   logic                  rsp_raised_ff, rsp_raised_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   cpms_pkg::alu_op_type  alu_op;
   cpms_pkg::alu_res_type alu_res;
   logic                  walk_done;
   logic                  out_free;
   logic                  accept;

   cpms_alu u_alu (
      .op  (alu_op),
      .a   (v_ff),
      .res (alu_res)
   );

   assign accept    = req_valid && (state_ff == cpms_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign walk_done = (start_ff == '0) || (v_ff < start_ff) ||
                      (v_ff == cpms_pkg::VALUE_WIDTH'(1)) ||
                      (v_ff == cpms_pkg::VALUE_WIDTH'(2));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cpms_pkg::ST_IDLE:    if (req_valid) state_in = cpms_pkg::ST_CHECK;
         cpms_pkg::ST_CHECK: begin
            state_in = walk_done ? cpms_pkg::ST_FINISH : cpms_pkg::ST_STRIP_V;
         end
         cpms_pkg::ST_STRIP_V: if (v_ff[0]) state_in = cpms_pkg::ST_INC;
         cpms_pkg::ST_INC: begin
            state_in = alu_res.over ? cpms_pkg::ST_FINISH : cpms_pkg::ST_STRIP_I;
         end
         cpms_pkg::ST_STRIP_I: begin
            if (alpha_ff == cpms_pkg::ALPHA_WIDTH'(cpms_pkg::ALPHA_LIMIT + 1)) begin
               state_in = cpms_pkg::ST_FINISH;
            end else if (v_ff[0]) begin
               state_in = cpms_pkg::ST_TRIPLE;
            end
         end
         cpms_pkg::ST_TRIPLE: begin
            if (alpha_ff == '0) begin
               state_in = cpms_pkg::ST_DEC;
            end else if (alu_res.over) begin
               state_in = cpms_pkg::ST_FINISH;
            end
         end
         cpms_pkg::ST_DEC:     state_in = cpms_pkg::ST_UPDATE;
         cpms_pkg::ST_UPDATE:  state_in = cpms_pkg::ST_CHECK;
         cpms_pkg::ST_FINISH:  if (out_free) state_in = cpms_pkg::ST_IDLE;
         default:              state_in = cpms_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      start_in      = start_ff;
      v_in          = v_ff;
      best_in       = best_ff;
      alpha_in      = alpha_ff;
      raised_in     = raised_ff;
      ovf_in        = ovf_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_raised_in = rsp_raised_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      alu_op        = cpms_pkg::ALU_INC;
      unique case (state_ff)
         cpms_pkg::ST_IDLE: begin
            if (accept) begin
               start_in  = req_start_value[cpms_pkg::VALUE_WIDTH-1:0];
               v_in      = req_start_value[cpms_pkg::VALUE_WIDTH-1:0];
               raised_in = 1'b0;
               ovf_in    = 1'b0;
            end
         end
         cpms_pkg::ST_CHECK: begin
         end
         cpms_pkg::ST_STRIP_V: begin
            if (!v_ff[0]) v_in = v_ff >> 1;
         end
         cpms_pkg::ST_INC: begin
            alu_op   = cpms_pkg::ALU_INC;
            v_in     = alu_res.sum;
            alpha_in = '0;
            if (alu_res.over) ovf_in = 1'b1;
         end
         cpms_pkg::ST_STRIP_I: begin
            if (alpha_ff == cpms_pkg::ALPHA_WIDTH'(cpms_pkg::ALPHA_LIMIT + 1)) begin
               ovf_in = 1'b1;
            end else if (!v_ff[0]) begin
               v_in     = v_ff >> 1;
               alpha_in = alpha_ff + cpms_pkg::ALPHA_WIDTH'(1);
            end
         end
         cpms_pkg::ST_TRIPLE: begin
            alu_op = cpms_pkg::ALU_TRIPLE;
            if (alpha_ff != '0) begin
               if (alu_res.over) begin
                  ovf_in = 1'b1;
               end else begin
                  v_in     = alu_res.sum;
                  alpha_in = alpha_ff - cpms_pkg::ALPHA_WIDTH'(1);
               end
            end
         end
         cpms_pkg::ST_DEC: begin
            alu_op = cpms_pkg::ALU_DEC;
            v_in   = alu_res.sum;
         end
         cpms_pkg::ST_UPDATE: begin
            if (v_ff > best_ff) begin
               best_in   = v_ff;
               raised_in = 1'b1;
            end
         end
         cpms_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_max_in    = best_ff;
               rsp_raised_in = raised_ff;
               rsp_ovf_in    = ovf_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpms_pkg::ST_IDLE;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      v_ff          <= v_in;
      alpha_ff      <= alpha_in;
      raised_ff     <= raised_in;
      ovf_ff        <= ovf_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_raised_ff <= rsp_raised_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign req_stall           = (state_ff != cpms_pkg::ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_running_maximum = cpms_pkg::PORT_WIDTH'(rsp_max_ff);
   assign rsp_record_raised   = rsp_raised_ff;
   assign rsp_overflow_seen   = rsp_ovf_ff;

   a_best_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> best_ff >= $past(best_ff))
      else $error("running maximum decreased");

   a_triple_odd: assert property (@(posedge clock) disable iff (reset)
      state_ff == cpms_pkg::ST_TRIPLE |-> v_ff[0])
      else $error("even operand in multiply by three");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == cpms_pkg::ST_FINISH && out_free |=> rsp_valid_ff &&
      state_ff == cpms_pkg::ST_IDLE)
      else $error("finished path not delivered");

   a_raised_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_raised_ff |-> rsp_max_ff != '0)
      else $error("record raised with zero maximum");

endmodule
`default_nettype wire
